@@ sv/rbpp_pkg.sv @@
`default_nettype none

package rbpp_pkg;

    localparam int PTR_W  = 8;
    localparam int BYTE_W = 8;
    localparam int CFG_W  = 8;

    localparam logic [PTR_W-1:0] CAP_MIN   = 8'd2;
    localparam logic [PTR_W-1:0] CAP_RESET = 8'd255;

    typedef enum logic [0:0] {
        KIND_PUSH = 1'b0,
        KIND_POP  = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERWRITE = 2'd1,
        ST_DISCARD   = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef enum logic [0:0] {
        REG_CAPACITY    = 1'b0,
        REG_FULL_POLICY = 1'b1
    } reg_index_t;

    typedef enum logic [0:0] {
        POLICY_OVERWRITE = 1'b0,
        POLICY_DISCARD   = 1'b1
    } policy_t;

endpackage

`default_nettype wire

@@ sv/rbpp_if.sv @@
`default_nettype none

interface rbpp_req_if;
    logic                       valid;
    logic                       ready;
    rbpp_pkg::kind_t            kind;
    logic [rbpp_pkg::BYTE_W-1:0] push_byte;

    modport source (output valid, output kind, output push_byte, input ready);
    modport sink   (input valid, input kind, input push_byte, output ready);
endinterface

interface rbpp_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [rbpp_pkg::BYTE_W-1:0] pop_byte;
    logic [rbpp_pkg::PTR_W-1:0]  fill_count;
    rbpp_pkg::status_t           status;

    modport source (output valid, output pop_byte, output fill_count, output status,
                    input ready);
    modport sink   (input valid, input pop_byte, input fill_count, input status,
                    output ready);
endinterface

`default_nettype wire

@@ sv/ring_buffer_push_pop_back_unit.sv @@
// Channel   Modport  Payload                          Direction
// req       sink     kind, push_byte                  into the block
// rsp       source   pop_byte, fill_count, status     out of the block
// wr_*      plain    wr_index, wr_data                configuration writes
//
// Pointers and count update at the edge that accepts a request,
// and its result is valid in the next cycle. A new request is accepted every cycle
// while the result is taken; ready drops only while a result waits on rsp.
// The slot read of a pop is the registered read of the slot RAM.
// Reset clears pointers and count, sets capacity to 255 and the overwrite policy; the slot RAM holds no reset value.
`default_nettype none

module ring_buffer_push_pop_back_unit #(
    parameter int DEPTH = 256
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    rbpp_req_if.sink                        req,
    rbpp_rsp_if.source                      rsp,
    input  wire logic                       wr_en,
    input  wire rbpp_pkg::reg_index_t       wr_index,
    input  wire logic [rbpp_pkg::CFG_W-1:0] wr_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CAP_MAX_INT = (DEPTH - 1 > 255) ? 255 : DEPTH - 1;
    localparam logic [rbpp_pkg::PTR_W-1:0] CAP_MAX = rbpp_pkg::PTR_W'(CAP_MAX_INT);

    logic [rbpp_pkg::PTR_W-1:0] capacity_reg;
    rbpp_pkg::policy_t          policy_reg;

    logic [rbpp_pkg::PTR_W-1:0] head_reg, head_next;
    logic [rbpp_pkg::PTR_W-1:0] tail_reg, tail_next;
    logic [rbpp_pkg::PTR_W-1:0] count_reg, count_next;

    logic                       rsp_valid_reg;
    logic                       rsp_pop_reg, rsp_pop_next;
    logic [rbpp_pkg::PTR_W-1:0] rsp_fill_reg;
    rbpp_pkg::status_t          rsp_status_reg, status_next;

    logic                       req_acc;
    logic [rbpp_pkg::PTR_W-1:0] cap_eff;
    logic [rbpp_pkg::PTR_W:0]   tail_inc, head_inc;
    logic [rbpp_pkg::PTR_W-1:0] tail_adv, head_adv, tail_dec;
    logic                       ram_wr_en, ram_rd_en;
    logic [rbpp_pkg::BYTE_W-1:0] ram_rd_data;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign req_acc   = req.valid && req.ready;

    always_comb
    begin
        priority if (capacity_reg < rbpp_pkg::CAP_MIN)
            cap_eff = rbpp_pkg::CAP_MIN;
        else if (capacity_reg > CAP_MAX)
            cap_eff = CAP_MAX;
        else
            cap_eff = capacity_reg;
    end

    assign tail_inc = {1'b0, tail_reg} + 1'b1;
    assign head_inc = {1'b0, head_reg} + 1'b1;
    assign tail_adv = (tail_inc >= {1'b0, cap_eff}) ? '0 : tail_inc[rbpp_pkg::PTR_W-1:0];
    assign head_adv = (head_inc >= {1'b0, cap_eff}) ? '0 : head_inc[rbpp_pkg::PTR_W-1:0];
    assign tail_dec = (tail_reg == '0) ? cap_eff - 1'b1 : tail_reg - 1'b1;

    always_comb
    begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        status_next  = rbpp_pkg::ST_OK;
        rsp_pop_next = 1'b0;
        ram_wr_en    = 1'b0;
        ram_rd_en    = 1'b0;
        unique case (req.kind)
            rbpp_pkg::KIND_PUSH:
            begin
                priority if (count_reg == '0)
                begin
                    ram_wr_en  = 1'b1;
                    count_next = 8'd1;
                end
                else if (count_reg < cap_eff)
                begin
                    tail_next  = tail_adv;
                    ram_wr_en  = 1'b1;
                    count_next = count_reg + 1'b1;
                end
                else if (policy_reg == rbpp_pkg::POLICY_OVERWRITE)
                begin
                    tail_next   = tail_adv;
                    head_next   = head_adv;
                    ram_wr_en   = 1'b1;
                    status_next = rbpp_pkg::ST_OVERWRITE;
                end
                else
                begin
                    status_next = rbpp_pkg::ST_DISCARD;
                end
            end
            rbpp_pkg::KIND_POP:
            begin
                if (count_reg == '0)
                begin
                    status_next = rbpp_pkg::ST_EMPTY;
                end
                else
                begin
                    ram_rd_en    = 1'b1;
                    rsp_pop_next = 1'b1;
                    count_next   = count_reg - 1'b1;
                    if (count_reg == 8'd1)
                    begin
                        head_next = '0;
                        tail_next = '0;
                    end
                    else
                    begin
                        tail_next = tail_dec;
                    end
                end
            end
            default:
            begin
                status_next = rbpp_pkg::ST_OK;
            end
        endcase
    end

    rbpp_ram #(
        .WIDTH (rbpp_pkg::BYTE_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk     (clk),
        .wr_en   (req_acc && ram_wr_en),
        .wr_addr (AW'(tail_next)),
        .wr_data (req.push_byte),
        .rd_en   (req_acc && ram_rd_en),
        .rd_addr (AW'(tail_reg)),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= rbpp_pkg::CAP_RESET;
            policy_reg   <= rbpp_pkg::POLICY_OVERWRITE;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                rbpp_pkg::REG_CAPACITY:    capacity_reg <= wr_data;
                rbpp_pkg::REG_FULL_POLICY: policy_reg   <= rbpp_pkg::policy_t'(wr_data[0]);
                default:                   capacity_reg <= capacity_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_acc)
            begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                count_reg <= count_next;
            end
            if (req_acc)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            rsp_pop_reg    <= rsp_pop_next;
            rsp_fill_reg   <= count_next;
            rsp_status_reg <= status_next;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.pop_byte   = rsp_pop_reg ? ram_rd_data : '0;
    assign rsp.fill_count = rsp_fill_reg;
    assign rsp.status     = rsp_status_reg;

    // A pop that empties the buffer returns both pointers to slot zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_acc && req.kind == rbpp_pkg::KIND_POP && count_reg == 8'd1
        |=> head_reg == '0 && tail_reg == '0)
        else $error("pointers not cleared after the last pop");

    // A discarded push leaves the fill and both pointers untouched.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_acc && status_next == rbpp_pkg::ST_DISCARD
        |=> count_reg == $past(count_reg) && tail_reg == $past(tail_reg)
            && head_reg == $past(head_reg))
        else $error("discarded push changed the buffer state");

    // A result appears only for a request accepted in the cycle before.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(req_acc))
        else $error("result without an accepted request");

    // No request is taken while a result is stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && !rsp.ready |-> !req_acc)
        else $error("request accepted over a stalled result");

endmodule

`default_nettype wire

@@ sv/rbpp_ram.sv @@
`default_nettype none

module rbpp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire
